>>> rtl/core/arm32ic_pkg.sv
// Package for the ARM instruction classifier.
// Holds the instruction code enumeration and the decode functions.
// No dependencies.
package arm32ic_pkg;

  localparam int unsigned CodeWidth = 8;

  typedef enum logic [CodeWidth-1:0] {
    C_UNDEFINED = 8'd0,
    C_MRS, C_MSR_REG, C_CLZ, C_BX, C_BLX2, C_QADD, C_QSUB, C_QDADD, C_QDSUB,
    C_BKPT, C_SMLAXY, C_SMLALXY, C_SMLAWY, C_SMULXY, C_SMULWY,
    C_MUL, C_MLA, C_UMULL, C_UMLAL, C_SMULL, C_SMLAL, C_SWP, C_SWPB,
    C_LDRH, C_STRH, C_LDRSB, C_LDRD, C_LDRSH,
    C_PLD, C_BLX1, C_LDC2, C_STC2, C_CDP2, C_MRC2, C_MCR2,
    C_AND, C_EOR, C_SUB, C_RSB, C_ADD, C_ADC, C_SBC, C_RSC,
    C_TST, C_TSTP, C_TEQ, C_TEQP, C_CMP, C_CMPP, C_CMN, C_CMNP,
    C_ORR, C_MOV, C_BIC, C_MVN,
    C_STR, C_LDR, C_STRB, C_LDRB, C_STRT, C_LDRT, C_STRBT, C_LDRBT,
    C_FCMPEZS, C_FCMPES, C_FABSS, C_FSITOS, C_FTOSIS, C_FSQRTS, C_FTOUIS,
    C_FADDS, C_FCMPS, C_FUITOS, C_FCMPZS, C_FCPYS, C_FNEGS, C_FDIVS,
    C_FMACS, C_FNMACS, C_FNMSCS, C_FNMULS, C_FMRS, C_FMSTAT, C_FMRX,
    C_FMSCS, C_FMSR, C_FMULS, C_FMXR, C_FSUBS,
    C_FMACD, C_FMDLR, C_FNMACD, C_FDIVD, C_FMULD, C_FMDHR, C_FNMULD,
    C_FMSCD, C_FMRDL, C_FNMSCD, C_FLDD, C_FABSD, C_FSQRTD, C_FCMPED,
    C_FCMPEZD, C_FCVTSD, C_FCVTDS, C_FSITOD, C_FTOUID, C_FTOSID,
    C_FCMPD, C_FCMPZD, C_FCPYD, C_FNEGD, C_FUITOD, C_FADDD, C_FMRDH, C_FSUBD,
    C_STRD, C_MSR_IMM, C_LDM1, C_STM1, C_STM2, C_LDM2, C_LDM3, C_BL, C_B,
    C_MCRR, C_FSTS, C_FSTMS, C_FSTD, C_FSTMX, C_FSTMD, C_STC, C_MRRC,
    C_FLDS, C_FLDMS, C_FLDMX, C_FLDMD, C_LDC, C_SWI, C_MRC, C_MCR, C_CDP
  } code_t;

  localparam logic [3:0] CondAl   = 4'b1110;
  localparam logic [3:0] CondNv   = 4'b1111;
  localparam logic [3:0] CpSingle = 4'b1010;
  localparam logic [3:0] CpDouble = 4'b1011;

  function automatic code_t dec_misc(input logic [31:0] w);
    logic [4:0] sh;
    logic [3:0] fh;
    logic [7:0] hi8;
    code_t r;
    sh  = w[24:20];
    fh  = w[7:4];
    hi8 = w[27:20];
    r   = C_UNDEFINED;
    unique case (fh)
      4'h0: begin
        if (sh == 5'h10 || sh == 5'h14) r = C_MRS;
        else if (sh == 5'h12 || sh == 5'h16) r = C_MSR_REG;
      end
      4'h1: begin
        if (sh == 5'h16) r = C_CLZ;
        else if (sh == 5'h12) r = C_BX;
      end
      4'h3: if (sh == 5'h12) r = C_BLX2;
      4'h5: begin
        if (sh == 5'h10) r = C_QADD;
        else if (sh == 5'h12) r = C_QSUB;
        else if (sh == 5'h14) r = C_QDADD;
        else if (sh == 5'h16) r = C_QDSUB;
      end
      4'h7: if (sh == 5'h12 && w[31:28] == CondAl) r = C_BKPT;
      4'h8, 4'hA, 4'hC, 4'hE: begin
        if (hi8 == 8'h10) r = C_SMLAXY;
        else if (hi8 == 8'h14) r = C_SMLALXY;
        else if (hi8 == 8'h12) r = fh[1] ? C_SMULWY : C_SMLAWY;
        else if (hi8 == 8'h16) r = C_SMULXY;
      end
      default: r = C_UNDEFINED;
    endcase
    return r;
  endfunction

  function automatic code_t dec_mul_xls(input logic [31:0] w);
    code_t r;
    r = C_UNDEFINED;
    unique case (w[7:4])
      4'h9: begin
        unique case (w[24:20])
          5'h00, 5'h01: r = C_MUL;
          5'h02, 5'h03: r = C_MLA;
          5'h08, 5'h09: r = C_UMULL;
          5'h0A, 5'h0B: r = C_UMLAL;
          5'h0C, 5'h0D: r = C_SMULL;
          5'h0E, 5'h0F: r = C_SMLAL;
          5'h10: r = C_SWP;
          5'h14: r = C_SWPB;
          default: r = C_UNDEFINED;
        endcase
      end
      4'hB: r = w[20] ? C_LDRH : C_STRH;
      4'hD: r = w[20] ? C_LDRSB : C_LDRD;
      4'hF: r = w[20] ? C_LDRSH : C_UNDEFINED;
      default: r = C_UNDEFINED;
    endcase
    return r;
  endfunction

  function automatic code_t dec_uncond(input logic [31:0] w);
    code_t r;
    r = C_UNDEFINED;
    if (!w[27]) begin
      if (w[26] && w[24] && w[22] && !w[21] && w[20] && w[15:12] == 4'hF) r = C_PLD;
    end else begin
      unique case (w[26:25])
        2'd1: r = C_BLX1;
        2'd2: r = w[20] ? C_LDC2 : C_STC2;
        2'd3: begin
          if (w[24]) r = C_UNDEFINED;
          else if (!w[4]) r = C_CDP2;
          else r = w[20] ? C_MRC2 : C_MCR2;
        end
        default: r = C_UNDEFINED;
      endcase
    end
    return r;
  endfunction

  function automatic code_t dec_dp(input logic [31:0] w);
    logic [3:0] op;
    code_t r;
    op = w[24:21];
    if (!op[3]) r = code_t'(CodeWidth'(C_AND) + CodeWidth'(op));
    else if (op[3:2] == 2'b11) r = code_t'(CodeWidth'(C_ORR) + CodeWidth'(op[1:0]));
    else if (w[20]) r = code_t'(CodeWidth'(C_TST) + CodeWidth'({op[1:0], 1'b0}));
    else if (w[15:12] == 4'hF) r = code_t'(CodeWidth'(C_TST) + CodeWidth'({op[1:0], 1'b1}));
    else r = C_UNDEFINED;
    return r;
  endfunction

  function automatic code_t dec_ls(input logic [31:0] w);
    logic [1:0] sel;
    sel = {w[22], w[20]};
    if (!w[24] && w[21]) return code_t'(CodeWidth'(C_STRT) + CodeWidth'(sel));
    return code_t'(CodeWidth'(C_STR) + CodeWidth'(sel));
  endfunction

  function automatic code_t dec_vfp_s(input logic [31:0] w);
    logic [3:0] hi, lo, mz;
    logic l0, l4;
    code_t r;
    hi = {w[24], w[23], w[21], w[20]};
    lo = w[7:4];
    mz = w[19:16];
    l0 = (lo & 4'd5) == 4'd0;
    l4 = (lo & 4'd5) == 4'd4;
    r  = C_UNDEFINED;
    if (hi == 4'd0 && l0) r = C_FMACS;
    else if (hi == 4'd0 && l4) r = C_FNMACS;
    else if (hi == 4'd1 && l0) r = C_FMSCS;
    else if (hi == 4'd1 && l4) r = C_FNMSCS;
    else if (hi == 4'd2 && l0) r = C_FMULS;
    else if (hi == 4'd2 && l4) r = C_FNMULS;
    else if (hi == 4'd3 && l0) r = C_FADDS;
    else if (hi == 4'd3 && l4) r = C_FSUBS;
    else if (hi == 4'd4 && l0) r = C_FDIVS;
    else if (hi == 4'd7) begin
      if (lo == 4'hC || lo == 4'hE) begin
        if (lo == 4'hC && mz == 4'd5) r = C_FCMPEZS;
        else begin
          unique case (mz)
            4'h4: r = C_FCMPES;
            4'h0: r = C_FABSS;
            4'h8: r = C_FSITOS;
            4'hD: r = C_FTOSIS;
            4'h1: r = C_FSQRTS;
            4'hC: r = C_FTOUIS;
            default: r = C_UNDEFINED;
          endcase
        end
      end else if (lo == 4'h4 || lo == 4'h6) begin
        unique case (mz)
          4'h4: r = C_FCMPS;
          4'h8: r = C_FUITOS;
          4'h5: r = C_FCMPZS;
          4'hD: r = C_FTOSIS;
          4'h0: r = C_FCPYS;
          4'h1: r = C_FNEGS;
          4'hC: r = C_FTOUIS;
          default: r = C_UNDEFINED;
        endcase
      end
    end
    return r;
  endfunction

  function automatic code_t dec_vfp_d(input logic [31:0] w);
    logic [3:0] left, right, mid;
    logic dcp;
    code_t r;
    left  = w[23:20];
    right = w[7:4];
    mid   = w[19:16];
    dcp   = w[11:8] == CpDouble;
    r     = C_UNDEFINED;
    unique case (left)
      4'h0: begin
        if (right == 4'd0) r = C_FMACD;
        else if (right == 4'd4) r = C_FNMACD;
      end
      4'h8: if (right == 4'd0) r = C_FDIVD;
      4'h2: begin
        if (right == 4'd0) r = C_FMULD;
        else if (right == 4'd4) r = C_FNMULD;
      end
      4'h1: begin
        if (right == 4'd0) r = C_FMSCD;
        else if (right == 4'd4) r = C_FNMSCD;
        else if (dcp) r = C_FLDD;
      end
      4'h9: if (dcp) r = C_FLDD;
      4'hB: begin
        if (right == 4'hC) begin
          unique case (mid)
            4'h0: r = C_FABSD;
            4'h1: r = C_FSQRTD;
            4'h4: r = C_FCMPED;
            4'h5: r = C_FCMPEZD;
            4'h7: begin
              if (dcp) r = C_FCVTSD;
              else if (w[11:8] == CpSingle) r = C_FCVTDS;
            end
            4'h8: r = C_FSITOD;
            4'hC: r = C_FTOUID;
            4'hD: r = C_FTOSID;
            default: r = C_UNDEFINED;
          endcase
        end else if (right == 4'hE && mid == 4'd7) r = C_FCVTDS;
        else if (right == 4'hE && mid == 4'd8) r = C_FSITOD;
        else if (right == 4'h4) begin
          unique case (mid)
            4'h4: r = C_FCMPD;
            4'h5: r = C_FCMPZD;
            4'h0: r = C_FCPYD;
            4'h1: r = C_FNEGD;
            4'hD: r = C_FTOSID;
            4'hC: r = C_FTOUID;
            4'h8: r = C_FUITOD;
            default: r = C_UNDEFINED;
          endcase
        end else if (right == 4'h6 && mid == 4'd8) r = C_FUITOD;
      end
      4'h3: begin
        if (right == 4'd0) r = C_FADDD;
        else if (right == 4'd4) r = C_FSUBD;
      end
      4'hF: begin
        if (right == 4'hC && mid == 4'd7) r = C_FCVTSD;
        else if ((right == 4'hC || right == 4'h4) && mid == 4'hD) r = C_FTOSID;
        else if ((right == 4'hC || right == 4'h4) && mid == 4'hC) r = C_FTOUID;
      end
      default: r = C_UNDEFINED;
    endcase
    return r;
  endfunction

  function automatic code_t dec_cop_ls(input logic [31:0] w);
    logic [4:0] bc;
    logic [3:0] cp;
    code_t r;
    bc = w[24:20];
    cp = w[11:8];
    if (!w[20]) begin
      if (bc == 5'h04) r = C_MCRR;
      else if (cp == CpSingle) r = (w[24] && !w[21]) ? C_FSTS : C_FSTMS;
      else if (cp == CpDouble && !w[22]) begin
        if (w[24] && !w[21]) r = C_FSTD;
        else r = w[0] ? C_FSTMX : C_FSTMD;
      end else r = C_STC;
    end else begin
      if (bc == 5'h05) r = C_MRRC;
      else if ((bc & 5'h13) == 5'h11 && cp == CpSingle) r = C_FLDS;
      else if (cp == CpSingle) r = C_FLDMS;
      else if (cp == CpDouble && !w[22]) r = w[0] ? C_FLDMX : C_FLDMD;
      else r = C_LDC;
    end
    return r;
  endfunction

  function automatic code_t classify(input logic [31:0] w);
    logic  nv;
    code_t u;
    code_t r;
    nv = w[31:28] == CondNv;
    u  = dec_uncond(w);
    r  = C_UNDEFINED;
    if (nv && u != C_UNDEFINED) return u;
    unique case (w[27:25])
      3'd0: begin
        if (w[4] && w[7]) begin
          if (!w[20] && w[7:4] == 4'hF) r = C_STRD;
          else r = dec_mul_xls(w);
        end else if (w[24] && !w[23] && !w[20]) r = dec_misc(w);
        else r = dec_dp(w);
      end
      3'd1: begin
        if ({w[24], w[23], w[21], w[20]} == 4'h8) r = C_UNDEFINED;
        else if ({w[24], w[23], w[21], w[20]} == 4'hA) r = C_MSR_IMM;
        else r = dec_dp(w);
      end
      3'd2: r = dec_ls(w);
      3'd3: r = w[4] ? C_UNDEFINED : dec_ls(w);
      3'd4: begin
        if (nv) r = C_UNDEFINED;
        else if (!w[22]) r = w[20] ? C_LDM1 : C_STM1;
        else if (!w[21] && !w[20]) r = C_STM2;
        else if (!w[21] && w[20] && !w[15]) r = C_LDM2;
        else if (w[20] && w[15]) r = C_LDM3;
      end
      3'd5: r = w[24] ? C_BL : C_B;
      3'd6: r = dec_cop_ls(w);
      default: begin
        if (w[24]) r = nv ? C_UNDEFINED : C_SWI;
        else if (w[4]) r = w[20] ? C_MRC : C_MCR;
        else if (w[11:8] == CpSingle) r = dec_vfp_s(w);
        else if (w[11:8] == CpDouble) r = dec_vfp_d(w);
        else r = C_CDP;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/arm32_instruction_classifier.sv
// The result is registered and becomes valid in the cycle after the input transfer.
// Throughput: one instruction per cycle unless a full output is stalled; decode sits between input and result register.
// Output register accepts a new item whenever it is empty or being drained.
// Reset: synchronous active-high rst clears the output valid; instr_code is not reset.
// Top level of the ARM instruction classifier.
// Depends on arm32ic_pkg.
module arm32_instruction_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  instr_code
);

  logic load;

  assign in_stall = out_valid && out_stall;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      instr_code <= 8'(arm32ic_pkg::classify(instr_word));
    end
  end

endmodule

>>> rtl/core/arm32ic_checker.sv
// Port-level checker for the ARM instruction classifier.
// Depends on arm32ic_pkg; bound to arm32_instruction_classifier.
module arm32ic_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] instr_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  instr_code
);

  a_code: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid &&
      instr_code == 8'(arm32ic_pkg::classify($past(instr_word))))
    else $error("wrong code after transfer");

  a_stall_only_full: assert property (@(posedge clk) in_stall |-> out_valid && out_stall)
    else $error("stall without full output");

  a_range: assert property (@(posedge clk) disable iff (rst) out_valid |-> instr_code <= 8'd143)
    else $error("code out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(instr_code))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

endmodule

bind arm32_instruction_classifier arm32ic_checker u_checker (.*);
